// File: rtl/pattern_match_counter_defines.svh
// assertion macros shared by the pattern match counter rtl
`ifndef PATTERN_MATCH_COUNTER_DEFINES_SVH
`define PATTERN_MATCH_COUNTER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define PMC_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pmc same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define PMC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pmc next-cycle check failed");

`endif

// File: rtl/pmc_pkg.sv
// shared types and constants of the pattern match counter
`timescale 1ns / 1ps
`default_nettype none

package pmc_pkg;

  localparam int unsigned OP_W      = 2;
  localparam int unsigned SYM_W     = 8;
  localparam int unsigned OUT_CNT_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_TEXT  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef struct packed {
    logic                 match;
    logic [OUT_CNT_W-1:0] count;
    logic                 dropped;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/pmc_if.sv
// valid/ready channel interfaces for input and result items
`timescale 1ns / 1ps
`default_nettype none

interface pmc_in_if
  import pmc_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [SYM_W-1:0] symbol;

  modport source (output valid, output operation, output symbol, input ready);
  modport sink   (input valid, input operation, input symbol, output ready);
endinterface

interface pmc_out_if
  import pmc_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic                 match;
  logic [OUT_CNT_W-1:0] match_count;
  logic                 dropped;

  modport source (output valid, output match, output match_count, output dropped,
                  input ready);
  modport sink   (input valid, input match, input match_count, input dropped,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/pmc_ram.sv
// simple dual-port memory, one write and one registered read per cycle
`timescale 1ns / 1ps
`default_nettype none

module pmc_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 8,
  parameter int unsigned AW    = 5
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/pmc_seq.sv
// sequencer: prefix-function walk with one shared byte compare per cycle
`timescale 1ns / 1ps
`default_nettype none
`include "pattern_match_counter_defines.svh"

module pmc_seq
  import pmc_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = 32,
  parameter int unsigned COUNT_BITS  = 32,
  parameter int unsigned LW          = 5,
  parameter int unsigned LENW        = 6
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [OP_W-1:0]  in_op_i,
  input  wire logic [SYM_W-1:0] in_sym_i,
  output logic                  pat_we_o,
  output logic      [LW-1:0]    pat_waddr_o,
  output logic      [SYM_W-1:0] pat_wdata_o,
  output logic      [LW-1:0]    pat_raddr_o,
  input  wire logic [SYM_W-1:0] pat_rdata_i,
  output logic                  fail_we_o,
  output logic      [LW-1:0]    fail_waddr_o,
  output logic      [LW-1:0]    fail_wdata_o,
  output logic      [LW-1:0]    fail_raddr_o,
  input  wire logic [LW-1:0]    fail_rdata_i,
  output logic                  res_valid_o,
  input  wire logic             res_ready_i,
  output res_t                  res_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LINK = 5'b00010,
    S_CMP  = 5'b00100,
    S_TAIL = 5'b01000,
    S_RESP = 5'b10000
  } state_e;

  state_e                state_q, state_d;
  logic [OP_W-1:0]       op_q, op_d;
  logic [SYM_W-1:0]      sym_q, sym_d;
  logic [LENW-1:0]       len_q, len_d;
  logic [LW-1:0]         ms_q, ms_d;
  logic [LW-1:0]         k_q, k_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic                  match_q, match_d;
  logic                  dropped_q, dropped_d;

  logic [LW-1:0]   k_nxt;
  logic            tail_rd;
  logic            cmp_hit;
  logic [LENW-1:0] k_new;
  logic [LENW-1:0] len_m1;

  assign cmp_hit    = (pat_rdata_i == sym_q);
  assign len_m1     = len_q - LENW'(1);
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    sym_d        = sym_q;
    len_d        = len_q;
    ms_d         = ms_q;
    k_d          = k_q;
    cnt_d        = cnt_q;
    match_d      = match_q;
    dropped_d    = dropped_q;
    k_nxt        = k_q;
    tail_rd      = 1'b0;
    k_new        = '0;
    pat_we_o     = 1'b0;
    fail_we_o    = 1'b0;
    pat_wdata_o  = sym_q;
    fail_wdata_o = '0;
    res_valid_o  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        k_nxt = ms_q;
        if (in_valid_i) begin
          op_d      = in_op_i;
          sym_d     = in_sym_i;
          match_d   = 1'b0;
          dropped_d = 1'b0;
          state_d   = S_RESP;
          if (in_op_i == OP_LOAD) begin
            // fetch the link of the last stored position
            tail_rd = 1'b1;
            if (len_q == LENW'(MAX_PATTERN)) begin
              dropped_d = 1'b1;
            end else if (len_q == '0) begin
              pat_we_o     = 1'b1;
              fail_we_o    = 1'b1;
              pat_wdata_o  = in_sym_i;
              fail_wdata_o = '0;
              len_d        = len_q + LENW'(1);
              ms_d         = '0;
            end else begin
              state_d = S_LINK;
            end
          end else if (in_op_i == OP_TEXT) begin
            if (len_q != '0) begin
              k_d     = ms_q;
              state_d = S_CMP;
            end
          end else if (in_op_i == OP_CLEAR) begin
            len_d = '0;
            ms_d  = '0;
            cnt_d = '0;
          end
        end
      end
      S_LINK: begin
        k_nxt   = fail_rdata_i;
        k_d     = fail_rdata_i;
        state_d = S_CMP;
      end
      S_CMP: begin
        if (!cmp_hit && (k_q != '0)) begin
          // mismatch: follow the failure link and compare again
          k_nxt = fail_rdata_i;
          k_d   = fail_rdata_i;
        end else begin
          k_new = cmp_hit ? (LENW'(k_q) + LENW'(1)) : '0;
          if (op_q == OP_LOAD) begin
            pat_we_o     = 1'b1;
            fail_we_o    = 1'b1;
            fail_wdata_o = k_new[LW-1:0];
            len_d        = len_q + LENW'(1);
            ms_d         = '0;
            state_d      = S_RESP;
          end else if (k_new == len_q) begin
            match_d = 1'b1;
            if (cnt_q != '1) begin
              cnt_d = cnt_q + COUNT_BITS'(1);
            end
            tail_rd = 1'b1;
            state_d = S_TAIL;
          end else begin
            ms_d    = k_new[LW-1:0];
            state_d = S_RESP;
          end
        end
      end
      S_TAIL: begin
        // full occurrence: resume from the link of the last position
        ms_d    = fail_rdata_i;
        state_d = S_RESP;
      end
      S_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign pat_waddr_o  = len_q[LW-1:0];
  assign fail_waddr_o = len_q[LW-1:0];
  assign pat_raddr_o  = k_nxt;
  assign fail_raddr_o = tail_rd ? len_m1[LW-1:0] : (k_nxt - LW'(1));

  assign res_o = '{match: match_q, count: OUT_CNT_W'(cnt_q), dropped: dropped_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      len_q     <= '0;
      ms_q      <= '0;
      cnt_q     <= '0;
      match_q   <= 1'b0;
      dropped_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      len_q     <= len_d;
      ms_q      <= ms_d;
      cnt_q     <= cnt_d;
      match_q   <= match_d;
      dropped_q <= dropped_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    sym_q <= sym_d;
    k_q   <= k_d;
  end

  `PMC_ASSERT_IMPL(a_len_bound, clk_i, rst_ni, 1'b1, len_q <= LENW'(MAX_PATTERN))
  `PMC_ASSERT_IMPL(a_ms_below_len, clk_i, rst_ni, len_q != '0, LENW'(ms_q) < len_q)
  `PMC_ASSERT_IMPL(a_k_below_len, clk_i, rst_ni, state_q == S_CMP, LENW'(k_q) < len_q)
  `PMC_ASSERT_NEXT(a_clear_zeroes, clk_i, rst_ni, in_valid_i && in_ready_o && in_op_i == OP_CLEAR, cnt_q == '0 && len_q == '0)

endmodule

`default_nettype wire

// File: rtl/pattern_match_counter.sv
// Pattern match counter: counts overlapping occurrences of a loaded pattern in a
// byte stream using the prefix (failure) function. Items carry an operation (load
// pattern byte, text byte, clear) and a byte; each item yields one result with the
// match flag, the saturating count since the last clear and the dropped flag. The
// block takes one item at a time. Clear, an unused operation code, a dropped
// load, the first pattern byte and a text byte with no pattern loaded go from
// accept straight to the result. Other loads and text bytes run a compare loop
// over the pattern and failure-table memories, one byte compare and one failure
// link per cycle. A load first fetches the link of the last stored position; a
// completed occurrence adds a fetch of the link to resume from. Each loop compares
// 1 up to the pattern length positions. A result waiting in the output register
// does not hold off the next item until that item's own result is ready.
`timescale 1ns / 1ps
`default_nettype none

module pattern_match_counter
  import pmc_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = 32,
  parameter int unsigned COUNT_BITS  = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pmc_in_if.sink    in_i,
  pmc_out_if.source out_o
);

  localparam int unsigned LW   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned LENW = $clog2(MAX_PATTERN + 1);

  logic             pat_we;
  logic [LW-1:0]    pat_waddr;
  logic [SYM_W-1:0] pat_wdata;
  logic [LW-1:0]    pat_raddr;
  logic [SYM_W-1:0] pat_rdata;
  logic             fail_we;
  logic [LW-1:0]    fail_waddr;
  logic [LW-1:0]    fail_wdata;
  logic [LW-1:0]    fail_raddr;
  logic [LW-1:0]    fail_rdata;
  logic             res_valid;
  logic             res_ready;
  res_t             res;

  logic                 out_valid_q;
  logic                 out_match_q;
  logic [OUT_CNT_W-1:0] out_count_q;
  logic                 out_dropped_q;

  pmc_ram #(
    .DEPTH (MAX_PATTERN),
    .WIDTH (SYM_W),
    .AW    (LW)
  ) u_pat_ram (
    .clk_i   (clk_i),
    .we_i    (pat_we),
    .waddr_i (pat_waddr),
    .wdata_i (pat_wdata),
    .raddr_i (pat_raddr),
    .rdata_o (pat_rdata)
  );

  pmc_ram #(
    .DEPTH (MAX_PATTERN),
    .WIDTH (LW),
    .AW    (LW)
  ) u_fail_ram (
    .clk_i   (clk_i),
    .we_i    (fail_we),
    .waddr_i (fail_waddr),
    .wdata_i (fail_wdata),
    .raddr_i (fail_raddr),
    .rdata_o (fail_rdata)
  );

  pmc_seq #(
    .MAX_PATTERN (MAX_PATTERN),
    .COUNT_BITS  (COUNT_BITS),
    .LW          (LW),
    .LENW        (LENW)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .in_op_i      (in_i.operation),
    .in_sym_i     (in_i.symbol),
    .pat_we_o     (pat_we),
    .pat_waddr_o  (pat_waddr),
    .pat_wdata_o  (pat_wdata),
    .pat_raddr_o  (pat_raddr),
    .pat_rdata_i  (pat_rdata),
    .fail_we_o    (fail_we),
    .fail_waddr_o (fail_waddr),
    .fail_wdata_o (fail_wdata),
    .fail_raddr_o (fail_raddr),
    .fail_rdata_i (fail_rdata),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  // output register takes a result while empty or while the sink takes the held one
  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_match_q   <= res.match;
      out_count_q   <= res.count;
      out_dropped_q <= res.dropped;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.match       = out_match_q;
  assign out_o.match_count = out_count_q;
  assign out_o.dropped     = out_dropped_q;

endmodule

`default_nettype wire

// File: bench/tb_pattern_match_counter.sv
// self-checking testbench for the pattern match counter: directed table, then random streams
`timescale 1ns / 1ps

module tb_pattern_match_counter;
  import pmc_pkg::*;

  localparam int unsigned MAX_PAT        = 32;
  localparam int unsigned RANDOM_ITEMS   = 1600;
  localparam int unsigned HOLDOFF_AT     = 600;
  localparam int unsigned HOLDOFF_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES   = 64;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  // operation code the block must ignore
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_e;

  typedef struct {
    logic [OP_W-1:0]  op;
    logic [SYM_W-1:0] sym;
    bit               fixed;
    res_t             want;
  } byte_op_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [SYM_W-1:0] sym;
    int unsigned      reps;
    bit               fixed;
    res_t             want;
  } row_t;

  localparam res_t ZERO_TALLY = '{match: 1'b0, count: '0, dropped: 1'b0};
  localparam res_t DROP_TALLY = '{match: 1'b0, count: '0, dropped: 1'b1};

  // directed rows; a typed tally is used only where it is obvious
  localparam int unsigned N_ROWS = 27;
  localparam row_t DIRECTED_ROWS [N_ROWS] = '{
    '{OP_TEXT,  8'h00, 1,  1'b1, ZERO_TALLY},  // text with empty pattern
    '{OP_SPARE, 8'hff, 1,  1'b1, ZERO_TALLY},
    '{OP_LOAD,  8'hff, 1,  1'b0, ZERO_TALLY},
    '{OP_TEXT,  8'hff, 2,  1'b0, ZERO_TALLY},  // one-byte pattern hits every time
    '{OP_TEXT,  8'h00, 1,  1'b0, ZERO_TALLY},
    '{OP_CLEAR, 8'h5a, 1,  1'b1, ZERO_TALLY},
    '{OP_LOAD,  8'h00, 2,  1'b0, ZERO_TALLY},
    '{OP_TEXT,  8'h00, 3,  1'b0, ZERO_TALLY},  // overlapping hits
    '{OP_LOAD,  8'h01, 1,  1'b0, ZERO_TALLY},  // load after text restarts the match
    '{OP_TEXT,  8'h01, 1,  1'b0, ZERO_TALLY},
    '{OP_TEXT,  8'h00, 2,  1'b0, ZERO_TALLY},
    '{OP_TEXT,  8'h01, 1,  1'b0, ZERO_TALLY},
    '{OP_SPARE, 8'h00, 1,  1'b0, ZERO_TALLY},
    '{OP_CLEAR, 8'hff, 1,  1'b1, ZERO_TALLY},
    '{OP_LOAD,  8'ha5, 32, 1'b0, ZERO_TALLY},  // fill the store
    '{OP_LOAD,  8'h3c, 1,  1'b1, DROP_TALLY},
    '{OP_TEXT,  8'ha5, 34, 1'b0, ZERO_TALLY},
    '{OP_TEXT,  8'h5a, 1,  1'b0, ZERO_TALLY},
    '{OP_CLEAR, 8'h00, 1,  1'b1, ZERO_TALLY},
    '{OP_LOAD,  8'h61, 1,  1'b0, ZERO_TALLY},
    '{OP_LOAD,  8'h62, 1,  1'b0, ZERO_TALLY},
    '{OP_LOAD,  8'h61, 1,  1'b0, ZERO_TALLY},
    '{OP_TEXT,  8'h61, 1,  1'b0, ZERO_TALLY},
    '{OP_TEXT,  8'h62, 1,  1'b0, ZERO_TALLY},
    '{OP_TEXT,  8'h61, 1,  1'b0, ZERO_TALLY},
    '{OP_TEXT,  8'h62, 1,  1'b0, ZERO_TALLY},
    '{OP_TEXT,  8'h61, 1,  1'b0, ZERO_TALLY}
  };

  logic clk_i;
  logic rst_ni;

  pmc_in_if  byte_in ();
  pmc_out_if result_out ();

  pattern_match_counter u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_in),
    .out_o  (result_out)
  );

  always #4 clk_i = ~clk_i;

  // predictor state
  logic [SYM_W-1:0] pat_mem  [MAX_PAT];
  logic [5:0]       fail_mem [MAX_PAT];
  logic [5:0]       pat_len;
  logic [5:0]       cur_state;
  logic [31:0]      hits;

  byte_op_t    byte_ops_q [$];
  res_t        tally_q [$];
  res_t        head_tally;
  int unsigned next_idx;
  int unsigned n_accepted;
  int unsigned n_loads, n_dropped, n_text, n_hits, n_clears, n_spare;
  int unsigned mismatches;
  int unsigned burst_left, gap_left;
  int unsigned quiet_cycles;
  int unsigned holdoff_left;
  bit          holdoff_done;
  rx_mode_e    rx_mode;
  int unsigned rx_mode_left, rx_tick;

  function automatic logic [5:0] extend_prefix(logic [5:0] k_in, logic [SYM_W-1:0] b);
    logic [5:0] k;
    k = k_in;
    while (k != 0 && pat_mem[k] != b) k = fail_mem[k - 1];
    if (pat_mem[k] == b) k = k + 1;
    return k;
  endfunction

  function automatic res_t kmp_step(logic [OP_W-1:0] op, logic [SYM_W-1:0] b);
    res_t       r;
    logic [5:0] k;
    r = '0;
    case (op)
      OP_LOAD: begin
        if (pat_len >= MAX_PAT) begin
          r.dropped = 1'b1;
        end else begin
          k = '0;
          if (pat_len != 0) k = extend_prefix(fail_mem[pat_len - 1], b);
          pat_mem[pat_len]  = b;
          fail_mem[pat_len] = k;
          pat_len           = pat_len + 1;
          cur_state         = '0;
        end
      end
      OP_TEXT: begin
        if (pat_len != 0) begin
          k = extend_prefix(cur_state, b);
          if (k >= pat_len) begin
            r.match = 1'b1;
            if (hits != '1) hits = hits + 1;
            k = fail_mem[pat_len - 1];
          end
          cur_state = k;
        end
      end
      OP_CLEAR: begin
        pat_len   = '0;
        cur_state = '0;
        hits      = '0;
      end
      default: ;
    endcase
    r.count = hits;
    return r;
  endfunction

  function automatic void push_byte_op(logic [OP_W-1:0] op, logic [SYM_W-1:0] sym,
                                       bit fixed = 1'b0, res_t want = '0);
    byte_op_t c;
    c.op    = op;
    c.sym   = sym;
    c.fixed = fixed;
    c.want  = want;
    byte_ops_q.insert(byte_ops_q.size(), c);
  endfunction

  function automatic void note_accepted(byte_op_t c);
    res_t r;
    r = kmp_step(c.op, c.sym);
    tally_q.insert(tally_q.size(), c.fixed ? c.want : r);
    n_accepted++;
    case (c.op)
      OP_LOAD:  begin n_loads++; if (r.dropped) n_dropped++; end
      OP_TEXT:  begin n_text++; if (r.match) n_hits++; end
      OP_CLEAR: n_clears++;
      default:  n_spare++;
    endcase
  endfunction

  task automatic flag_mismatch(string field, longint unsigned want, longint unsigned got);
    mismatches++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
  endtask

  // sender: bursts with random gaps, holds the item until it is taken
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      byte_in.valid <= 1'b0;
    end else begin
      if (byte_in.valid && byte_in.ready) begin
        note_accepted(byte_ops_q[next_idx]);
        next_idx++;
      end
      if (byte_in.valid && !byte_in.ready) begin
        // keep offering the same item
      end else if (next_idx >= byte_ops_q.size()) begin
        byte_in.valid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        byte_in.valid <= 1'b0;
      end else begin
        byte_in.valid     <= 1'b1;
        byte_in.operation <= byte_ops_q[next_idx].op;
        byte_in.symbol    <= byte_ops_q[next_idx].sym;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
                                                  : $urandom_range(1, 30);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
  end

  // receiver: changing stall patterns plus one long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      result_out.ready <= 1'b0;
    end else if (holdoff_left > 0) begin
      holdoff_left--;
      result_out.ready <= 1'b0;
    end else if (!holdoff_done && n_accepted >= HOLDOFF_AT) begin
      holdoff_done = 1'b1;
      holdoff_left = HOLDOFF_CYCLES;
      result_out.ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_e'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(20, 200);
      end
      rx_mode_left--;
      rx_tick++;
      case (rx_mode)
        RX_OPEN:     result_out.ready <= 1'b1;
        RX_COIN:     result_out.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE:   result_out.ready <= ($urandom_range(0, 3) == 0);
        default:     result_out.ready <= (rx_tick % 4 != 3);
      endcase
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && result_out.valid && result_out.ready) begin
      if (tally_q.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing pending, match=%0b count=%0d dropped=%0b",
                 $time, result_out.match, result_out.match_count, result_out.dropped);
      end else begin
        head_tally = tally_q.pop_front();
        if (result_out.match !== head_tally.match)
          flag_mismatch("match", head_tally.match, result_out.match);
        if (result_out.match_count !== head_tally.count)
          flag_mismatch("match_count", head_tally.count, result_out.match_count);
        if (result_out.dropped !== head_tally.dropped)
          flag_mismatch("dropped", head_tally.dropped, result_out.dropped);
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (byte_in.valid && byte_in.ready) ||
        (result_out.valid && result_out.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results pending",
               $time, WATCHDOG_LIMIT, tally_q.size());
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned      random_items, n, n_alpha, plen, copy_len, text_len, roll, i, j;
    logic [SYM_W-1:0] alpha [3];
    logic [SYM_W-1:0] pat   [MAX_PAT];
    logic [SYM_W-1:0] b;
    logic [OP_W-1:0]  op;

    clk_i              = 1'b0;
    rst_ni             = 1'b0;
    byte_in.valid      = 1'b0;
    byte_in.operation  = OP_CLEAR;
    byte_in.symbol     = '0;
    result_out.ready   = 1'b0;
    pat_len            = '0;
    cur_state          = '0;
    hits               = '0;
    next_idx           = 0;
    n_accepted         = 0;
    mismatches         = 0;
    burst_left         = 0;
    gap_left           = 0;
    quiet_cycles       = 0;
    holdoff_left       = 0;
    holdoff_done       = 1'b0;
    rx_mode            = RX_OPEN;
    rx_mode_left       = 0;
    rx_tick            = 0;
    {n_loads, n_dropped, n_text, n_hits, n_clears, n_spare} = '0;

    for (i = 0; i < N_ROWS; i++)
      repeat (DIRECTED_ROWS[i].reps)
        push_byte_op(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].sym,
                     DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].want);

    // random part: mostly load-a-pattern-then-scan phases over a tiny alphabet
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          op = 2'($urandom_range(0, 3));
          push_byte_op(op, 8'($urandom));
          if (op != OP_SPARE) random_items++;
        end
      end else begin
        if ($urandom_range(0, 3) != 0) begin
          push_byte_op(OP_CLEAR, 8'($urandom));
          random_items++;
        end
        n_alpha = $urandom_range(1, 3);
        for (i = 0; i < n_alpha; i++) alpha[i] = 8'($urandom);
        roll = $urandom_range(0, 99);
        plen = (roll < 70) ? $urandom_range(1, 5) :
               (roll < 92) ? $urandom_range(6, MAX_PAT) :
                             $urandom_range(MAX_PAT + 1, MAX_PAT + 4);
        for (i = 0; i < plen; i++) begin
          b = alpha[$urandom_range(0, n_alpha - 1)];
          if (i < MAX_PAT) pat[i] = b;
          push_byte_op(OP_LOAD, b);
          random_items++;
        end
        if (plen > MAX_PAT) plen = MAX_PAT;
        text_len = $urandom_range(10, 60);
        n = 0;
        while (n < text_len) begin
          roll = $urandom_range(0, 99);
          if (roll < 35) begin
            for (j = 0; j < plen; j++) push_byte_op(OP_TEXT, pat[j]);
            n += plen;
          end else if (roll < 45) begin
            // broken copy: a prefix then a stray byte
            copy_len = $urandom_range(0, plen - 1);
            for (j = 0; j < copy_len; j++) push_byte_op(OP_TEXT, pat[j]);
            push_byte_op(OP_TEXT, alpha[$urandom_range(0, n_alpha - 1)]);
            n += copy_len + 1;
          end else if (roll < 48) begin
            push_byte_op(OP_TEXT, 8'($urandom));
            n++;
          end else begin
            push_byte_op(OP_TEXT, alpha[$urandom_range(0, n_alpha - 1)]);
            n++;
          end
        end
        random_items += n;
      end
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (next_idx < byte_ops_q.size()) @(posedge clk_i);
    while (tally_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d items: %0d loads (%0d dropped), %0d text bytes, %0d hits",
             n_accepted, n_loads, n_dropped, n_text, n_hits);
    $display("also %0d clears and %0d spare codes, %0d mismatches",
             n_clears, n_spare, mismatches);
    if (mismatches == 0 && tally_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
